### hw/rtl/duplicate_frame_filter_defines.svh
// ----------------------------------------------------------------------------
// Duplicate frame filter assertion macros
// Shared property wrappers for the checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_FRAME_FILTER_DEFINES_SVH
`define DUPLICATE_FRAME_FILTER_DEFINES_SVH

// same-cycle implication
`define DFF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("duplicate_frame_filter: same-cycle check failed");

// next-cycle implication
`define DFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("duplicate_frame_filter: next-cycle check failed");

`endif

### hw/rtl/dff_pkg.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter package
// Entry type, controller state and ring control shared by the filter modules.
// ----------------------------------------------------------------------------
package dff_pkg;

  localparam int DEVICE_COUNT_DEF       = 2;
  localparam int SOURCES_PER_DEVICE_DEF = 16;
  localparam int ADDR_W                 = 64;
  localparam int SEQ_W                  = 8;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic dev;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage

### hw/rtl/dff_cell.sv
// ----------------------------------------------------------------------------
// Source table cell
// Holds one source entry and loads its neighbor's entry when the ring shifts.
// ----------------------------------------------------------------------------
module dff_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  dff_pkg::entry_t d,
  output dff_pkg::entry_t q
);
  import dff_pkg::*;

  logic              valid;
  logic [ADDR_W-1:0] addr;
  logic [SEQ_W-1:0]  seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      addr <= d.addr;
      seq  <= d.seq;
    end
  end

  assign q = '{valid: valid, addr: addr, seq: seq};

endmodule

### hw/rtl/dff_ctrl.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter controller
// Rotates the selected ring once (not for a device out of range), matching or inserting at the head cell.
// ----------------------------------------------------------------------------
module dff_ctrl #(
  parameter int DEVICE_COUNT       = dff_pkg::DEVICE_COUNT_DEF,
  parameter int SOURCES_PER_DEVICE = dff_pkg::SOURCES_PER_DEVICE_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     device,
  input  logic [dff_pkg::ADDR_W-1:0] source_address,
  input  logic [dff_pkg::SEQ_W-1:0]  sequence_number,
  input  dff_pkg::entry_t          head,
  output dff_pkg::entry_t          wb,
  output dff_pkg::ring_ctl_t       ctl,
  output logic                     busy,
  output logic                     done,
  output logic                     deliver,
  output logic                     new_source,
  output logic                     table_full
);
  import dff_pkg::*;

  localparam int CNT_W = (SOURCES_PER_DEVICE > 1) ? $clog2(SOURCES_PER_DEVICE) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SOURCES_PER_DEVICE - 1);

  state_t            state, state_next;
  logic              dev;
  logic [ADDR_W-1:0] addr;
  logic [SEQ_W-1:0]  seq;
  logic [CNT_W-1:0]  cnt;
  logic              found, dup, placed, skip;
  logic              in_range, hit, take_free;

  assign in_range  = (device == 1'b0) || (DEVICE_COUNT > 1);
  assign hit       = head.valid && (head.addr == addr);
  assign take_free = !head.valid && !found && !placed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      dev    <= device;
      addr   <= source_address;
      seq    <= sequence_number;
      cnt    <= '0;
      found  <= 1'b0;
      dup    <= 1'b0;
      placed <= 1'b0;
      skip   <= !in_range;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
      if (hit) begin
        found <= 1'b1;
        dup   <= (head.seq == seq);
      end
      if (take_free) begin
        placed <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = in_range ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (cnt == LAST) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    ctl.shift  = 1'b0;
    ctl.dev    = dev;
    wb         = head;
    deliver    = !dup || skip;
    new_source = !found && !skip;
    table_full = !found && !placed && !skip;
    case (state)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
        ctl.shift = 1'b1;
        if (hit) begin
          wb.seq = seq;
        end else if (take_free) begin
          wb = '{valid: 1'b1, addr: addr, seq: seq};
        end
      end
      ST_RESP: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

### hw/rtl/duplicate_frame_filter.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter
// Per-device rings of source cells; one rotation per frame finds the source,
// refreshes its sequence number or stores it in the first free cell.
// Order: start is taken in idle, the ring is scanned one cell per cycle, then
//   done rises; a device out of range is not scanned.
// Frames: a new frame is taken only after done; busy blocks start.
// Reset: synchronous rst empties every table; done cannot be stalled.
// ----------------------------------------------------------------------------
module duplicate_frame_filter #(
  parameter int DEVICE_COUNT       = dff_pkg::DEVICE_COUNT_DEF,
  parameter int SOURCES_PER_DEVICE = dff_pkg::SOURCES_PER_DEVICE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       device,
  input  logic [dff_pkg::ADDR_W-1:0] source_address,
  input  logic [dff_pkg::SEQ_W-1:0]  sequence_number,
  output logic                       done,
  output logic                       deliver,
  output logic                       new_source,
  output logic                       table_full
);
  import dff_pkg::*;

  entry_t    cell_q [DEVICE_COUNT][SOURCES_PER_DEVICE];
  entry_t    head, wb;
  ring_ctl_t ctl;

  always_comb begin
    head = cell_q[0][0];
    for (int d = 0; d < DEVICE_COUNT; d++) begin
      if ({31'd0, ctl.dev} == 32'(d)) begin
        head = cell_q[d][0];
      end
    end
  end

  for (genvar d = 0; d < DEVICE_COUNT; d++) begin : g_dev
    logic shift;
    assign shift = ctl.shift && ({31'd0, ctl.dev} == 32'(d));
    for (genvar k = 0; k < SOURCES_PER_DEVICE; k++) begin : g_cell
      entry_t d_in;
      if (k == SOURCES_PER_DEVICE - 1) begin : g_tail
        assign d_in = wb;
      end else begin : g_mid
        assign d_in = cell_q[d][k+1];
      end
      dff_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (d_in),
        .q     (cell_q[d][k])
      );
    end
  end

  dff_ctrl #(
    .DEVICE_COUNT       (DEVICE_COUNT),
    .SOURCES_PER_DEVICE (SOURCES_PER_DEVICE)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .device          (device),
    .source_address  (source_address),
    .sequence_number (sequence_number),
    .head            (head),
    .wb              (wb),
    .ctl             (ctl),
    .busy            (busy),
    .done            (done),
    .deliver         (deliver),
    .new_source      (new_source),
    .table_full      (table_full)
  );

endmodule

### hw/rtl/dff_checker.sv
// ----------------------------------------------------------------------------
// Duplicate frame filter checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "duplicate_frame_filter_defines.svh"

module dff_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic deliver,
  input logic new_source,
  input logic table_full
);

  `DFF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `DFF_ASSERT_NOW(a_done_busy, done, busy)
  `DFF_ASSERT_NEXT(a_done_single, done, !done)
  `DFF_ASSERT_NOW(a_drop_known, done && !deliver, !new_source && !table_full)
  `DFF_ASSERT_NOW(a_full_new, done && table_full, new_source && deliver)

endmodule

bind duplicate_frame_filter dff_checker u_dff_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .deliver    (deliver),
  .new_source (new_source),
  .table_full (table_full)
);
